// File: design/abkf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_pkg
// Shared constants and saturation helpers for the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package abkf_pkg;

	localparam logic [31:0] RST_ANGLE_NOISE = 32'd4294967;
	localparam logic [31:0] RST_BIAS_NOISE  = 32'd12884902;
	localparam logic [31:0] RST_MEAS_NOISE  = 32'd128849019;
	localparam logic [31:0] RST_START_ANGLE = 32'd0;

	localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
	localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
	localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
	localparam logic [1:0] REG_START_ANGLE = 2'd3;

	localparam logic [47:0] LIM48 = 48'h7FFF_FFFF_FFFF;

	function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
		if (v > 51'sh7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -51'sh8000_0000) begin
			return -32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
		if (v > 51'sh7FFF_FFFF_FFFF) begin
			return 48'sh7FFF_FFFF_FFFF;
		end else if (v < -51'sh8000_0000_0000) begin
			return -48'sh8000_0000_0000;
		end
		return v[47:0];
	endfunction

endpackage

// File: design/angle_bias_kalman_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter
// Two-state angle/gyro-bias Kalman filter, fixed point, one shared
// multiplier and one restoring divider under a sequencer.
// ----------------------------------------------------------------------------
// channel  dir  word
// s_*      in   measured_angle, measured_rate, time_step
// m_*      out  angle_estimate, unbiased_rate
// APB      in   four tuning/start registers at 0x0, 0x4, 0x8, 0xC
//
// One word takes ten products on the 48x16 multiplier (3 partial products,
// load and round) and two 80-step gain divisions, a zero gain instead when
// the divisor is zero. s_tready is high only while the sequencer is idle. A
// result waits in the output register until taken; the next word may be
// accepted meanwhile. Reset clears all filter state and loads the defaults.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [25:0] measured_angle, [53:26] measured_rate, [69:54] time_step
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] angle_estimate, [63:32] unbiased_rate
	output logic [63:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RATE = 4'd1;
	localparam logic [3:0] ST_LOAD = 4'd2;
	localparam logic [3:0] ST_MUL  = 4'd3;
	localparam logic [3:0] ST_FIN  = 4'd4;
	localparam logic [3:0] ST_DIVS = 4'd5;
	localparam logic [3:0] ST_DIV  = 4'd6;
	localparam logic [3:0] ST_Y    = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] op_q;
	logic [1:0] mcnt_q;
	logic [6:0] dcnt_q;
	logic       dsel_q;

	logic [31:0] qa_q, qb_q, rn_q, start_q;
	logic signed [31:0] ang_q, bias_q, rate_q;
	logic signed [47:0] p00_q, p01_q, p10_q, p11_q;
	logic signed [47:0] k0_q, k1_q, s_q, t_q;
	logic signed [32:0] y_q;
	logic signed [25:0] za_q;
	logic signed [27:0] zr_q;
	logic [15:0] dt_q;

	logic [47:0] ma_q, mb_q;
	logic        mneg_q;
	logic [95:0] acc_q;
	logic        msh32_q;

	logic [47:0] un_q, ud_q, r_q;
	logic [48:0] dq_q;
	logic        dovf_q, dneg_q;

	logic [63:0] out_q;
	logic        mvalid_q;

	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;
	assign m_tdata  = out_q;

	always_comb begin
		unique case (paddr[3:2])
			abkf_pkg::REG_ANGLE_NOISE: prdata = qa_q;
			abkf_pkg::REG_BIAS_NOISE:  prdata = qb_q;
			abkf_pkg::REG_MEAS_NOISE:  prdata = rn_q;
			default:                   prdata = start_q;
		endcase
	end

	// operand select per product step
	logic signed [48:0] opa, opb;
	always_comb begin
		opa = '0;
		opb = '0;
		unique case (op_q)
			4'd0: begin opa = {33'd0, dt_q}; opb = 49'(rate_q); end
			4'd1: begin opa = {33'd0, dt_q}; opb = 49'(p11_q); end
			4'd2: begin opa = {33'd0, dt_q}; opb = 49'(s_q); end
			4'd3: begin opa = {17'd0, qb_q}; opb = {33'd0, dt_q}; end
			4'd4: begin opa = 49'(k0_q); opb = 49'(y_q); end
			4'd5: begin opa = 49'(k1_q); opb = 49'(y_q); end
			4'd6: begin opa = 49'(k1_q); opb = 49'(p00_q); end
			4'd7: begin opa = 49'(k0_q); opb = 49'(p00_q); end
			4'd8: begin opa = 49'(k1_q); opb = 49'(p01_q); end
			default: begin opa = 49'(k0_q); opb = 49'(p01_q); end
		endcase
	end

	logic signed [48:0] opa_mag, opb_mag;
	assign opa_mag = opa[48] ? -opa : opa;
	assign opb_mag = opb[48] ? -opb : opb;

	// partial product
	logic [15:0] chunk;
	logic [63:0] pprod;
	logic [95:0] pshift;
	always_comb begin
		unique case (mcnt_q)
			2'd0: chunk = mb_q[15:0];
			2'd1: chunk = mb_q[31:16];
			default: chunk = mb_q[47:32];
		endcase
		pprod = ma_q * chunk;
		unique case (mcnt_q)
			2'd0: pshift = {32'd0, pprod};
			2'd1: pshift = {16'd0, pprod, 16'd0};
			default: pshift = {pprod, 32'd0};
		endcase
	end

	// round, limit, sign
	logic [96:0] rsum, rshf;
	logic [47:0] rmag;
	logic signed [48:0] m_s;
	always_comb begin
		rsum = {1'b0, acc_q} + (msh32_q ? 97'h8000_0000 : 97'h8000);
		rshf = msh32_q ? (rsum >> 32) : (rsum >> 16);
		rmag = (rshf > {49'd0, abkf_pkg::LIM48}) ? abkf_pkg::LIM48 : rshf[47:0];
		m_s  = mneg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
	end

	// divider step
	logic [48:0] r_sh;
	logic        d_ge;
	logic [47:0] r_nx;
	logic [48:0] q_sh, q_nx;
	logic        ovf_nx;
	logic [47:0] kmag;
	logic signed [47:0] k_fin;
	always_comb begin
		r_sh   = {r_q, un_q[47]};
		d_ge   = r_sh >= {1'b0, ud_q};
		r_nx   = d_ge ? 48'(r_sh - {1'b0, ud_q}) : r_sh[47:0];
		q_sh   = {dq_q[47:0], d_ge};
		ovf_nx = dovf_q || (q_sh > {1'b0, abkf_pkg::LIM48});
		q_nx   = dovf_q ? dq_q : q_sh;
		kmag   = ovf_nx ? abkf_pkg::LIM48 : q_nx[47:0];
		k_fin  = dneg_q ? -$signed(kmag) : $signed(kmag);
	end

	logic signed [47:0] dnum;
	logic signed [48:0] dnum_mag, s_mag;
	assign dnum     = dsel_q ? p10_q : p00_q;
	assign dnum_mag = dnum[47] ? -49'(dnum) : 49'(dnum);
	assign s_mag    = s_q[47] ? -49'(s_q) : 49'(s_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= '0;
			mcnt_q   <= '0;
			dcnt_q   <= '0;
			dsel_q   <= 1'b0;
			mvalid_q <= 1'b0;
			qa_q     <= abkf_pkg::RST_ANGLE_NOISE;
			qb_q     <= abkf_pkg::RST_BIAS_NOISE;
			rn_q     <= abkf_pkg::RST_MEAS_NOISE;
			start_q  <= abkf_pkg::RST_START_ANGLE;
			ang_q    <= '0;
			bias_q   <= '0;
			rate_q   <= '0;
			p00_q    <= '0;
			p01_q    <= '0;
			p10_q    <= '0;
			p11_q    <= '0;
		end else begin
			if (mvalid_q && m_tready) begin
				mvalid_q <= 1'b0;
			end
			if (cfg_wr) begin
				unique case (paddr[3:2])
					abkf_pkg::REG_ANGLE_NOISE: qa_q <= pwdata;
					abkf_pkg::REG_BIAS_NOISE:  qb_q <= pwdata;
					abkf_pkg::REG_MEAS_NOISE:  rn_q <= pwdata;
					default: begin
						start_q <= pwdata;
						ang_q   <= $signed(pwdata);
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						za_q    <= s_tdata[25:0];
						zr_q    <= s_tdata[53:26];
						dt_q    <= s_tdata[69:54];
						state_q <= ST_RATE;
					end
				end
				ST_RATE: begin
					rate_q  <= abkf_pkg::sat32(51'(zr_q) - 51'(bias_q));
					op_q    <= 4'd0;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					ma_q    <= opa_mag[47:0];
					mb_q    <= opb_mag[47:0];
					mneg_q  <= opa[48] != opb[48];
					msh32_q <= op_q >= 4'd4;
					acc_q   <= '0;
					mcnt_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					acc_q  <= acc_q + pshift;
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					op_q    <= op_q + 4'd1;
					state_q <= ST_LOAD;
					unique case (op_q)
						4'd0: ang_q <= abkf_pkg::sat32(51'(ang_q) + 51'(m_s));
						4'd1: begin
							t_q <= m_s[47:0];
							s_q <= abkf_pkg::sat48(51'(m_s) - 51'(p01_q) - 51'(p10_q)
								+ $signed({19'd0, qa_q}));
						end
						4'd2: begin
							p00_q <= abkf_pkg::sat48(51'(p00_q) + 51'(m_s));
							p01_q <= abkf_pkg::sat48(51'(p01_q) - 51'(t_q));
							p10_q <= abkf_pkg::sat48(51'(p10_q) - 51'(t_q));
						end
						4'd3: begin
							p11_q   <= abkf_pkg::sat48(51'(p11_q) + 51'(m_s));
							s_q     <= abkf_pkg::sat48(51'(p00_q) + $signed({19'd0, rn_q}));
							dsel_q  <= 1'b0;
							state_q <= ST_DIVS;
						end
						4'd4: ang_q <= abkf_pkg::sat32(51'(ang_q) + 51'(m_s));
						4'd5: bias_q <= abkf_pkg::sat32(51'(bias_q) + 51'(m_s));
						4'd6: p10_q <= abkf_pkg::sat48(51'(p10_q) - 51'(m_s));
						4'd7: p00_q <= abkf_pkg::sat48(51'(p00_q) - 51'(m_s));
						4'd8: p11_q <= abkf_pkg::sat48(51'(p11_q) - 51'(m_s));
						default: begin
							p01_q   <= abkf_pkg::sat48(51'(p01_q) - 51'(m_s));
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_DIVS: begin
					if (s_q == '0) begin
						if (dsel_q) begin
							k1_q    <= '0;
							state_q <= ST_Y;
						end else begin
							k0_q   <= '0;
							dsel_q <= 1'b1;
						end
					end else begin
						un_q    <= dnum_mag[47:0];
						ud_q    <= s_mag[47:0];
						dneg_q  <= dnum[47] != s_q[47];
						r_q     <= '0;
						dq_q    <= '0;
						dovf_q  <= 1'b0;
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					un_q   <= {un_q[46:0], 1'b0};
					r_q    <= r_nx;
					dq_q   <= q_nx;
					dovf_q <= ovf_nx;
					dcnt_q <= dcnt_q + 7'd1;
					if (dcnt_q == 7'd79) begin
						if (dsel_q) begin
							k1_q    <= k_fin;
							state_q <= ST_Y;
						end else begin
							k0_q    <= k_fin;
							dsel_q  <= 1'b1;
							state_q <= ST_DIVS;
						end
					end
				end
				ST_Y: begin
					y_q     <= 33'(za_q) - 33'(ang_q);
					op_q    <= 4'd4;
					state_q <= ST_LOAD;
				end
				ST_OUT: begin
					if (!mvalid_q || m_tready) begin
						out_q    <= {rate_q, ang_q};
						mvalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: test/angle_bias_kalman_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_tb
// Streams IMU samples through the angle/bias Kalman filter under random
// idling and backpressure. A fixed-point model of the filter predicts each
// angle/rate result, and each result is checked in order. Several tuning
// settings are loaded over APB between phases, the extremes among them.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_tb;

	localparam longint SAT48 = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SAT32 = 64'sh0000_0000_7FFF_FFFF;
	localparam int ZA_MAX = 23592960;
	localparam int ZR_MAX = 131072000;

	typedef struct {
		logic signed [25:0] za;
		logic signed [27:0] zr;
		logic [15:0]        dt;
	} sample_t;

	typedef struct {
		logic [31:0] angle;
		logic [31:0] rate;
	} estimate_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	angle_bias_kalman_filter dut (.*);

	always #5 clk = ~clk;

	sample_t   sample_q[$];
	estimate_t estimate_q[$];
	int        errors = 0;
	int        gap_max = 9;
	int        stall_max = 9;
	int        hold_req = 0;
	int        hold_cnt = 0;
	int        gap_cnt = 0;
	int        stall_cnt = 0;
	logic      s_acc = 1'b0;
	logic      m_acc = 1'b0;

	// filter mirror
	logic [31:0] q_angle, q_bias, r_meas;
	longint      f_angle, f_bias, f_rate, p00, p01, p10, p11;

	function automatic longint clip(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim - 1) return -lim - 1;
		return v;
	endfunction

	// round(a*b / 2^sh) ties away from zero, magnitude limited to 2^47-1
	function automatic longint mul_round(longint a, longint b, int sh);
		logic [63:0]  x, y;
		logic [127:0] p;
		bit           neg;
		neg = (a < 0) != (b < 0);
		x = (a < 0) ? -a : a;
		y = (b < 0) ? -b : b;
		p = {64'd0, x} * {64'd0, y};
		p = p + (128'd1 << (sh - 1));
		p = p >> sh;
		if (p > 128'(SAT48)) p = 128'(SAT48);
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	// num * 2^32 / den, truncated, magnitude limited to 2^47-1
	function automatic longint kalman_gain(longint num, longint den);
		logic [63:0] un, ud, r, q;
		bit          neg, done;
		neg = (num < 0) != (den < 0);
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		r = 0;
		q = 0;
		done = 0;
		if (den == 0) return 0;
		for (int i = 79; i >= 0; i--) begin
			if (!done) begin
				r = (r << 1) | ((i >= 32) ? ((un >> (i - 32)) & 64'd1) : 64'd0);
				q = q << 1;
				if (r >= ud) begin
					r = r - ud;
					q = q | 64'd1;
				end
				if (q > 64'(SAT48)) begin
					q = 64'(SAT48);
					done = 1;
				end
			end
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic estimate_t filter_update(sample_t smp);
		longint    dt, t, s, k0, k1, y, a00, a01;
		estimate_t e;
		dt = longint'(smp.dt);
		f_rate = clip(longint'(smp.zr) - f_bias, SAT32);
		f_angle = clip(f_angle + mul_round(dt, f_rate, 16), SAT32);
		t = mul_round(dt, p11, 16);
		s = clip(t - p01 - p10 + longint'(q_angle), SAT48);
		p00 = clip(p00 + mul_round(dt, s, 16), SAT48);
		p01 = clip(p01 - t, SAT48);
		p10 = clip(p10 - t, SAT48);
		p11 = clip(p11 + mul_round(longint'(q_bias), dt, 16), SAT48);
		s = clip(p00 + longint'(r_meas), SAT48);
		k0 = kalman_gain(p00, s);
		k1 = kalman_gain(p10, s);
		y = longint'(smp.za) - f_angle;
		f_angle = clip(f_angle + mul_round(k0, y, 32), SAT32);
		f_bias = clip(f_bias + mul_round(k1, y, 32), SAT32);
		a00 = p00;
		a01 = p01;
		p00 = clip(p00 - mul_round(k0, a00, 32), SAT48);
		p01 = clip(p01 - mul_round(k0, a01, 32), SAT48);
		p10 = clip(p10 - mul_round(k1, a00, 32), SAT48);
		p11 = clip(p11 - mul_round(k1, a01, 32), SAT48);
		e.angle = f_angle[31:0];
		e.rate = f_rate[31:0];
		return e;
	endfunction

	// check first, then predict: a result never belongs to the word taken on the same edge
	always @(posedge clk) begin
		estimate_t e;
		sample_t   smp;
		s_acc <= s_tvalid && s_tready;
		m_acc <= m_tvalid && m_tready;
		if (arst_n && m_tvalid && m_tready) begin
			if (estimate_q.size() == 0) begin
				$display("%t unexpected result: actual %h", $realtime, m_tdata);
				errors++;
			end else begin
				e = estimate_q.pop_front();
				if (m_tdata[31:0] !== e.angle) begin
					$display("%t angle_estimate mismatch: expected %h actual %h",
						$realtime, e.angle, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== e.rate) begin
					$display("%t unbiased_rate mismatch: expected %h actual %h",
						$realtime, e.rate, m_tdata[63:32]);
					errors++;
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			smp.za = s_tdata[25:0];
			smp.zr = s_tdata[53:26];
			smp.dt = s_tdata[69:54];
			estimate_q.push_back(filter_update(smp));
		end
	end

	// sample driver
	always @(negedge clk) begin
		sample_t smp;
		if (arst_n && !(s_tvalid && !s_acc)) begin
			if (gap_cnt > 0) begin
				gap_cnt <= gap_cnt - 1;
				s_tvalid <= 1'b0;
			end else if (sample_q.size() > 0) begin
				smp = sample_q.pop_front();
				s_tdata <= {2'b00, smp.dt, smp.zr, smp.za};
				s_tvalid <= 1'b1;
				gap_cnt <= $urandom_range(0, gap_max);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long receiver hold-off
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_cnt <= hold_req;
			hold_req = 0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// result sink
	always @(negedge clk) begin
		int st;
		st = stall_cnt;
		if (m_acc) st = $urandom_range(0, stall_max);
		if (!arst_n || hold_cnt > 0) begin
			m_tready <= 1'b0;
		end else if (st > 0) begin
			m_tready <= 1'b0;
			st = st - 1;
		end else begin
			m_tready <= 1'b1;
		end
		stall_cnt <= st;
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			abkf_pkg::REG_ANGLE_NOISE: q_angle = val;
			abkf_pkg::REG_BIAS_NOISE:  q_bias = val;
			abkf_pkg::REG_MEAS_NOISE:  r_meas = val;
			abkf_pkg::REG_START_ANGLE: f_angle = longint'($signed(val));
		endcase
	endtask

	task automatic drain();
		while (sample_q.size() > 0 || s_tvalid || estimate_q.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic sample_t mk_sample(int za, int zr, int dt);
		sample_t smp;
		smp.za = 26'(za);
		smp.zr = 28'(zr);
		smp.dt = 16'(dt);
		return smp;
	endfunction

	// mostly a plausible slow motion; about one word in five, at random, is full-range noise
	task automatic push_random(int n);
		int za, zr, dt;
		za = 0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				za = int'($urandom_range(0, 2 * ZA_MAX)) - ZA_MAX;
				zr = int'($urandom_range(0, 2 * ZR_MAX)) - ZR_MAX;
				dt = $urandom_range(0, 65535);
			end else begin
				za = za + int'($urandom_range(0, 131072)) - 65536;
				if (za > ZA_MAX) za = ZA_MAX;
				if (za < -ZA_MAX) za = -ZA_MAX;
				zr = int'($urandom_range(0, 2 * 6553600)) - 6553600;
				dt = $urandom_range(1, 1311);
			end
			sample_q.push_back(mk_sample(za, zr, dt));
		end
	endtask

	initial begin
		logic [31:0] cfg [6][4];
		q_angle = abkf_pkg::RST_ANGLE_NOISE;
		q_bias = abkf_pkg::RST_BIAS_NOISE;
		r_meas = abkf_pkg::RST_MEAS_NOISE;
		f_angle = 0;
		f_bias = 0;
		f_rate = 0;
		p00 = 0;
		p01 = 0;
		p10 = 0;
		p11 = 0;
		cfg[0] = '{abkf_pkg::RST_ANGLE_NOISE, abkf_pkg::RST_BIAS_NOISE,
			abkf_pkg::RST_MEAS_NOISE, 32'h7FFF_FFFF};
		cfg[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000};
		cfg[2] = '{32'd0, 32'd0, 32'd0, 32'd0};
		cfg[3] = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0016_8000};
		cfg[4] = '{$urandom, $urandom, $urandom, $urandom};
		cfg[5] = '{abkf_pkg::RST_ANGLE_NOISE, abkf_pkg::RST_BIAS_NOISE,
			abkf_pkg::RST_MEAS_NOISE, abkf_pkg::RST_START_ANGLE};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// field extremes at reset settings
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				sample_q.push_back(mk_sample(a == 0 ? ZA_MAX : a == 1 ? -ZA_MAX : 0,
					b == 0 ? ZR_MAX : b == 1 ? -ZR_MAX : 0, (a + b) % 3 == 0 ? 65535 : 0));
		sample_q.push_back(mk_sample(ZA_MAX, ZR_MAX, 65535));
		sample_q.push_back(mk_sample(-ZA_MAX, -ZR_MAX, 65535));
		sample_q.push_back(mk_sample(1, -1, 1));
		sample_q.push_back(mk_sample(-1, 1, 0));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			gap_max = (ph % 3 == 1) ? 0 : 9;
			stall_max = (ph % 3 == 2) ? 0 : 9;
			for (int r = 0; r < 4; r++) reg_write(r[1:0], cfg[ph][r]);
			push_random(ph == 2 ? 200 : 320);
			if (ph == 1) hold_req = 3000;
			drain();
		end

		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
